// ===== design/min_heap_priority_queue_assert.svh =====
// assertion macros used by the checker file
`ifndef MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define MHPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mhpq check failed");

// next-cycle implication, disabled while reset is active
`define MHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mhpq check failed");

`endif

// ===== design/mhpq_pkg.sv =====
package mhpq_pkg;

  localparam int DEPTH     = 63;
  localparam int KEY_W     = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int TOTAL_W   = 6;
  localparam int STATUS_W  = 2;
  localparam int OUT_RAW_W = 2 * KEY_W + TOTAL_W;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // operation broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } cell_op_t;

endpackage

// ===== design/mhpq_cell.sv =====
module mhpq_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mhpq_pkg::cell_op_t                  op,
  input  logic signed [mhpq_pkg::KEY_W-1:0]   value,
  input  logic signed [mhpq_pkg::KEY_W-1:0]   prev_key,
  input  logic                                prev_vld,
  input  logic                                prev_le,
  input  logic signed [mhpq_pkg::KEY_W-1:0]   next_key,
  input  logic                                next_vld,
  output logic signed [mhpq_pkg::KEY_W-1:0]   key,
  output logic                                vld,
  output logic                                le
);

  logic signed [mhpq_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                              vld_r, vld_nxt;

  // this key stays in place on insert when it is not above the new key
  assign le  = vld_r && (key_r <= value);
  assign key = key_r;
  assign vld = vld_r;

  always_comb begin
    key_nxt = key_r;
    vld_nxt = vld_r;
    if (op.ins) begin
      if (le) begin
        key_nxt = key_r;
        vld_nxt = vld_r;
      end else if (prev_le) begin
        key_nxt = value;
        vld_nxt = 1'b1;
      end else begin
        key_nxt = prev_key;
        vld_nxt = prev_vld;
      end
    end else if (op.del) begin
      key_nxt = next_key;
      vld_nxt = next_vld;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

endmodule

// ===== design/min_heap_priority_queue.sv =====
// channel | dir | tdata (low bit up)                          | tuser
// in_     | in  | value[31:0]                                 | cmd
// out_    | out | removed_value, top_value, entry_total, pad  | status
//
// every item passes through capture, one shift/compare step across the row of
// cells, then the result register load; the row updates all keys in that step
// reset (rst_n low, synchronous) empties the row and drops any pending result
// a new item is taken while the previous result still waits in the output register
// a stalled output holds the sequencer in its final step until the result is taken
module min_heap_priority_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mhpq_pkg::KEY_W-1:0]       in_tdata,   // value
  input  logic                             in_tuser,   // cmd
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mhpq_pkg::OUT_W-1:0]       out_tdata,  // removed_value, top_value, entry_total
  output logic [mhpq_pkg::STATUS_W-1:0]    out_tuser   // status
);

  localparam int DEPTH = mhpq_pkg::DEPTH;
  localparam int KEY_W = mhpq_pkg::KEY_W;
  localparam int CNT_W = mhpq_pkg::CNT_W;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                       state_r, state_nxt;
  logic                             cmd_r;
  logic signed [KEY_W-1:0]          value_r;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic signed [KEY_W-1:0]          removed_r, removed_nxt;
  logic [mhpq_pkg::STATUS_W-1:0]    status_r, status_nxt;

  logic                             out_vld_r, out_vld_nxt;
  logic signed [KEY_W-1:0]          out_removed_r;
  logic signed [KEY_W-1:0]          out_top_r;
  logic [mhpq_pkg::TOTAL_W-1:0]     out_total_r;
  logic [mhpq_pkg::STATUS_W-1:0]    out_status_r;

  mhpq_pkg::cell_op_t               op;

  // per-cell taps, read by the neighbors; cell 0's key also feeds the result
  logic signed [KEY_W-1:0] cell_key [DEPTH];
  logic                    cell_vld [DEPTH];
  logic                    cell_le  [DEPTH];

  logic in_acc;
  logic out_load;
  logic is_full;
  logic is_empty;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign out_load  = (state_r == S_FIN) && (!out_vld_r || out_tready);

  // operation reaches the cells only in the execute step and only when legal
  always_comb begin
    op.ins = (state_r == S_EXEC) && (cmd_r == mhpq_pkg::CMD_INSERT) && !is_full;
    op.del = (state_r == S_EXEC) && (cmd_r == mhpq_pkg::CMD_DELETE) && !is_empty;
  end

  // row of cells, cell 0 holds the minimum
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0] p_key;
    logic                    p_vld;
    logic                    p_le;
    logic signed [KEY_W-1:0] n_key;
    logic                    n_vld;

    if (i == 0) begin : g_first
      // head cell: an empty left neighbor that always lets the new key in
      assign p_key = '0;
      assign p_vld = 1'b0;
      assign p_le  = 1'b1;
    end else begin : g_mid
      assign p_key = cell_key[i-1];
      assign p_vld = cell_vld[i-1];
      assign p_le  = cell_le[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_key = '0;
      assign n_vld = 1'b0;
    end else begin : g_body
      assign n_key = cell_key[i+1];
      assign n_vld = cell_vld[i+1];
    end

    mhpq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (op),
      .value    (value_r),
      .prev_key (p_key),
      .prev_vld (p_vld),
      .prev_le  (p_le),
      .next_key (n_key),
      .next_vld (n_vld),
      .key      (cell_key[i]),
      .vld      (cell_vld[i]),
      .le       (cell_le[i])
    );
  end

  // sequencer, count and status
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt   = S_FIN;
        removed_nxt = '0;
        status_nxt  = mhpq_pkg::ST_OK;
        if (cmd_r == mhpq_pkg::CMD_INSERT) begin
          if (is_full) begin
            status_nxt = mhpq_pkg::ST_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end else begin
          if (is_empty) begin
            status_nxt = mhpq_pkg::ST_EMPTY;
          end else begin
            // root leaves before the row shifts left
            removed_nxt = cell_key[0];
            count_nxt   = count_r - 1'b1;
          end
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_tuser;
      value_r <= in_tdata;
    end
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    if (out_load) begin
      out_removed_r <= removed_r;
      out_top_r     <= is_empty ? '0 : cell_key[0];
      out_total_r   <= count_r[mhpq_pkg::TOTAL_W-1:0];
      out_status_r  <= status_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(mhpq_pkg::OUT_W - mhpq_pkg::OUT_RAW_W){1'b0}},
                       out_total_r, out_top_r, out_removed_r};
  assign out_tuser  = out_status_r;

endmodule

// ===== design/mhpq_checker.sv =====
`include "min_heap_priority_queue_assert.svh"

module mhpq_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mhpq_pkg::OUT_W-1:0]       out_tdata,
  input logic [mhpq_pkg::STATUS_W-1:0]    out_tuser
);

  logic [mhpq_pkg::KEY_W-1:0]                      removed;
  logic [mhpq_pkg::KEY_W-1:0]                      top;
  logic [mhpq_pkg::TOTAL_W-1:0]                    total;
  logic [mhpq_pkg::OUT_W+mhpq_pkg::STATUS_W-1:0]   out_all;
  logic                                            in_acc;
  logic                                            out_stall;
  logic                                            rep_full;
  logic                                            rep_empty;

  assign removed   = out_tdata[mhpq_pkg::KEY_W-1:0];
  assign top       = out_tdata[2*mhpq_pkg::KEY_W-1:mhpq_pkg::KEY_W];
  assign total     = out_tdata[mhpq_pkg::OUT_RAW_W-1:2*mhpq_pkg::KEY_W];
  assign out_all   = {out_tdata, out_tuser};
  assign in_acc    = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign rep_full  = out_tvalid && (out_tuser == mhpq_pkg::ST_FULL);
  assign rep_empty = out_tvalid && (out_tuser == mhpq_pkg::ST_EMPTY);

  // one item at a time: input closes right after an accept
  `MHPQ_ASSERT_NEXT(a_in_gap, clk, rst_n, in_acc, !in_tready)

  // stalled result holds
  `MHPQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_all))

  // an empty queue reports a zero top
  `MHPQ_ASSERT_NOW(a_empty_top, clk, rst_n, out_tvalid && total == '0, top == '0)

  // a delete on empty removes nothing and leaves the queue empty
  `MHPQ_ASSERT_NOW(a_del_empty, clk, rst_n, rep_empty, removed == '0 && total == '0)

  // a rejected insert only happens at full capacity
  `MHPQ_ASSERT_NOW(a_ins_full, clk, rst_n, rep_full,
                   removed == '0 && total == mhpq_pkg::TOTAL_W'(mhpq_pkg::DEPTH))

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (.*);
